@@ design/sao_pkg.sv @@
package sao_pkg;

   // channel and alpha widths
   localparam int ChanW  = 8;
   localparam int AlphaW = 16;
   localparam int NumW   = 24;

   // full alpha in 1/65025 units
   localparam logic [AlphaW-1:0] FullAlpha = 16'd65025;

   // steps of the colour divider, one quotient bit each
   localparam int DivSteps = ChanW;

   // configuration register indexes
   localparam int CsrAddrW = 1;
   localparam logic [CsrAddrW-1:0] RegOpacity = 1'd0;
   localparam logic [CsrAddrW-1:0] RegVisible = 1'd1;

   // one rgba pixel, red in the lowest bits
   typedef struct packed {
      logic [ChanW-1:0] alpha;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] red;
   } pixel_type;

   // side data that travels next to the colour divider
   typedef struct packed {
      logic             valid;
      logic             pass;
      logic [ChanW-1:0] alpha;
      pixel_type        dst;
   } side_type;

   // floor(x / 255) for x below 255 * 65536, by reciprocal and one correction
   function automatic logic [AlphaW-1:0] div255(input logic [NumW-1:0] x);
      logic [32:0] prod;
      logic [16:0] est;
      logic [24:0] rem;
      prod = {9'd0, x} + {1'b0, x, 8'd0};
      est  = prod[32:16];
      rem  = {1'b0, x} - ({est, 8'd0} - {8'd0, est});
      if (rem >= 25'd255) begin
         est = est + 17'd1;
      end
      return est[AlphaW-1:0];
   endfunction

endpackage

@@ design/straight_alpha_over_composite_core.sv @@
// Source-over compositing of straight-alpha rgba pixels, one pixel per word.
// req channel: tdata carries the source pixel and the destination pixel;
// rsp channel: tdata carries the composited pixel, one word per req word.
// csr port: index 0 sets the layer opacity (8 bits), index 1 sets the
// visible flag (bit 0); write only while no word is in flight.
// A word passes from req to rsp through four arithmetic stages (opacity scale,
// destination weight, divide by 255, colour products), the eight-stage colour
// divider and the output register.
// Throughput: one pixel per cycle; every stage holds a full pixel and the
// pipeline moves as one while a two-entry output buffer has room.
// Reset clears all valid bits and the buffer, sets opacity to 255 and the
// layer visible. When rsp_tready is low the output word holds; one more word
// is caught in the spare entry and req_tready then drops on the next cycle,
// so no word is lost or repeated. A hidden layer or a zero result alpha
// returns the destination pixel unchanged.
module straight_alpha_over_composite_core
   import sao_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // src red, green, blue, alpha, dst red, green, blue, alpha
   input  logic [63:0]         req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // out red, green, blue, alpha
   output logic [31:0]         rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [ChanW-1:0]    csr_wdata
);

   logic en;

   // configuration registers
   logic [ChanW-1:0] opacity_ff;
   logic             visible_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= 8'd255;
         visible_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            RegOpacity: opacity_ff <= csr_wdata;
            RegVisible: visible_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input unpack
   pixel_type src_pix, dst_pix;
   assign src_pix = req_tdata[31:0];
   assign dst_pix = req_tdata[63:32];

   // stage 1: scaled source alpha
   logic              v1_ff;
   logic [AlphaW-1:0] sa1_ff, sa1_in;
   pixel_type         src1_ff, dst1_ff;

   assign sa1_in = AlphaW'(src_pix.alpha) * AlphaW'(opacity_ff);

   // stage 2: destination alpha times remaining coverage
   logic              v2_ff;
   logic [AlphaW-1:0] sa2_ff;
   logic [NumW-1:0]   x2_ff, x2_in;
   pixel_type         src2_ff, dst2_ff;

   assign x2_in = NumW'(dst1_ff.alpha) * NumW'(FullAlpha - sa1_ff);

   // stage 3: destination weight
   logic              v3_ff;
   logic [AlphaW-1:0] sa3_ff, dw3_ff, dw3_in;
   pixel_type         src3_ff, dst3_ff;

   assign dw3_in = div255(x2_ff);

   // stage 4: output alpha and colour numerators
   logic              v4_ff;
   logic [AlphaW-1:0] oa4_ff, oa4_in;
   logic [NumW-1:0]   nr4_ff, ng4_ff, nb4_ff, nr4_in, ng4_in, nb4_in;
   pixel_type         dst4_ff;

   assign oa4_in = sa3_ff + dw3_ff;
   assign nr4_in = NumW'(src3_ff.red) * NumW'(sa3_ff)
                 + NumW'(dst3_ff.red) * NumW'(dw3_ff);
   assign ng4_in = NumW'(src3_ff.green) * NumW'(sa3_ff)
                 + NumW'(dst3_ff.green) * NumW'(dw3_ff);
   assign nb4_in = NumW'(src3_ff.blue) * NumW'(sa3_ff)
                 + NumW'(dst3_ff.blue) * NumW'(dw3_ff);

   // front stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa1_ff  <= sa1_in;
         src1_ff <= src_pix;
         dst1_ff <= dst_pix;
         sa2_ff  <= sa1_ff;
         x2_ff   <= x2_in;
         src2_ff <= src1_ff;
         dst2_ff <= dst1_ff;
         sa3_ff  <= sa2_ff;
         dw3_ff  <= dw3_in;
         src3_ff <= src2_ff;
         dst3_ff <= dst2_ff;
         oa4_ff  <= oa4_in;
         nr4_ff  <= nr4_in;
         ng4_ff  <= ng4_in;
         nb4_ff  <= nb4_in;
         dst4_ff <= dst3_ff;
      end
   end

   // colour dividers
   logic [ChanW-1:0] qr, qg, qb;

   sao_div u_div_red (
      .clock (clock),
      .en    (en),
      .num   (nr4_ff),
      .den   (oa4_ff),
      .quo   (qr)
   );

   sao_div u_div_green (
      .clock (clock),
      .en    (en),
      .num   (ng4_ff),
      .den   (oa4_ff),
      .quo   (qg)
   );

   sao_div u_div_blue (
      .clock (clock),
      .en    (en),
      .num   (nb4_ff),
      .den   (oa4_ff),
      .quo   (qb)
   );

   // side data line alongside the dividers
   side_type side_ff [DivSteps];
   side_type side_in;
   logic [AlphaW-1:0] alpha_full;

   assign alpha_full    = div255(NumW'(oa4_ff));
   assign side_in.valid = v4_ff;
   assign side_in.pass  = (oa4_ff == '0);
   assign side_in.alpha = alpha_full[ChanW-1:0];
   assign side_in.dst   = dst4_ff;

   for (genvar i = 0; i < DivSteps; i++) begin : g_side
      side_type side_src;
      if (i == 0) begin : g_first
         assign side_src = side_in;
      end else begin : g_next
         assign side_src = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else if (en) begin
            side_ff[i] <= side_src;
         end
      end
   end

   // result select
   side_type  last;
   pixel_type result;

   assign last = side_ff[DivSteps-1];

   always_comb begin
      if (last.pass || !visible_ff) begin
         result = last.dst;
      end else begin
         result.red   = qr;
         result.green = qg;
         result.blue  = qb;
         result.alpha = last.alpha;
      end
   end

   // output register with one spare entry
   logic      out_valid_ff, out_valid_in;
   logic      spare_valid_ff, spare_valid_in;
   pixel_type out_data_ff, out_data_in;
   pixel_type spare_data_ff, spare_data_in;
   logic      push, pop;

   assign en   = !spare_valid_ff;
   assign push = en && last.valid;
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in  = spare_data_ff;
      if (!out_valid_ff || pop) begin
         if (spare_valid_ff) begin
            out_valid_in   = 1'b1;
            out_data_in    = spare_data_ff;
            spare_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = result;
         end
      end else if (push) begin
         spare_valid_in = 1'b1;
         spare_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ design/sao_div.sv @@
module sao_div
   import sao_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [NumW-1:0]   num,
   input  logic [AlphaW-1:0] den,
   output logic [ChanW-1:0]  quo
);

   logic [NumW-1:0]   rem_ff [DivSteps];
   logic [AlphaW-1:0] den_ff [DivSteps];
   logic [ChanW-1:0]  quo_ff [DivSteps];

   // restoring division, one quotient bit per stage, msb first
   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic [NumW-1:0]   rem_src;
      logic [AlphaW-1:0] den_src;
      logic [ChanW-1:0]  quo_src;
      logic [NumW-1:0]   den_sh;
      logic              take;
      logic [NumW-1:0]   rem_in;
      logic [ChanW-1:0]  quo_in;

      if (i == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end

      assign den_sh = NumW'(den_src) << (DivSteps - 1 - i);
      assign take   = rem_src >= den_sh;
      assign rem_in = take ? rem_src - den_sh : rem_src;
      assign quo_in = {quo_src[ChanW-2:0], take};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DivSteps-1];

endmodule
